FILE: design/aalr_pkg.sv
// ----------------------------------------------------------------------------
// aalr_pkg
// Shared constants, controller states and the command/status bundles that
// join the line rasterizer controller and datapath.
// ----------------------------------------------------------------------------
package aalr_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 8;

  // Function codes of an input item
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_START,
    ST_MID,
    ST_END
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic emit_start;
    logic emit_mid;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic at_stop;
    logic next_at_stop;
  } status_t;

endpackage

FILE: design/aalr_ctrl.sv
// ----------------------------------------------------------------------------
// aalr_ctrl
// Controller: sequences load, gradient division and column emission, and
// owns the handshake of both channels.
// ----------------------------------------------------------------------------
module aalr_ctrl #(
  parameter int FRAC_BITS = aalr_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              func,
  output logic              result_valid,
  input  logic              result_stall,
  input  aalr_pkg::status_t status,
  output aalr_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  aalr_pkg::state_t state;
  aalr_pkg::state_t state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             load_acc;
  logic             step_acc;
  logic             emit;

  assign item_stall = (state == aalr_pkg::ST_DIV) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;
  assign load_acc   = accept && (func == aalr_pkg::FUNC_LOAD);
  assign step_acc   = accept && (func == aalr_pkg::FUNC_STEP);
  assign emit       = cmd.emit_start || cmd.emit_mid || cmd.emit_end;

  always_comb begin
    state_next = state;
    case (state)
      aalr_pkg::ST_IDLE: begin
        if (load_acc) state_next = aalr_pkg::ST_DIV;
      end
      aalr_pkg::ST_DIV: begin
        if (cnt == CNT_LAST) state_next = aalr_pkg::ST_START;
      end
      aalr_pkg::ST_START: begin
        if (load_acc) begin
          state_next = aalr_pkg::ST_DIV;
        end else if (step_acc) begin
          if (status.at_stop)           state_next = aalr_pkg::ST_IDLE;
          else if (status.next_at_stop) state_next = aalr_pkg::ST_END;
          else                          state_next = aalr_pkg::ST_MID;
        end
      end
      aalr_pkg::ST_MID: begin
        if (load_acc) begin
          state_next = aalr_pkg::ST_DIV;
        end else if (step_acc && status.next_at_stop) begin
          state_next = aalr_pkg::ST_END;
        end
      end
      aalr_pkg::ST_END: begin
        if (load_acc)      state_next = aalr_pkg::ST_DIV;
        else if (step_acc) state_next = aalr_pkg::ST_IDLE;
      end
      default: state_next = aalr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = load_acc;
    cmd.div_step   = (state == aalr_pkg::ST_DIV);
    cmd.div_last   = (state == aalr_pkg::ST_DIV) && (cnt == CNT_LAST);
    cmd.emit_start = step_acc && (state == aalr_pkg::ST_START);
    cmd.emit_mid   = step_acc && (state == aalr_pkg::ST_MID);
    cmd.emit_end   = step_acc && (state == aalr_pkg::ST_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= aalr_pkg::ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
      // hold a result until its transfer completes
      result_valid <= emit || (result_valid && result_stall);
    end
  end

`ifndef SYNTH
  a_load_starts_div: assert property (@(posedge clk) disable iff (rst)
    load_acc |=> (state == aalr_pkg::ST_DIV) && (cnt == '0))
    else $error("load did not start the divider");

  a_div_ends_in_start: assert property (@(posedge clk) disable iff (rst)
    ((state == aalr_pkg::ST_DIV) && (cnt == CNT_LAST)) |=> (state == aalr_pkg::ST_START))
    else $error("divider did not hand over to the start column");

  a_emit_shows_result: assert property (@(posedge clk) disable iff (rst)
    emit |=> result_valid)
    else $error("emitted column not presented");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(emit))
    else $error("result appeared without a column step");
`endif

endmodule

FILE: design/aalr_datapath.sv
// ----------------------------------------------------------------------------
// aalr_datapath
// Datapath: endpoint ordering, restoring gradient divider, minor-axis
// accumulator, weight generation and the result register.
// ----------------------------------------------------------------------------
module aalr_datapath #(
  parameter int COORD_BITS  = aalr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = aalr_pkg::FRAC_BITS_DEF,
  parameter int WEIGHT_BITS = aalr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  aalr_pkg::cmd_t         cmd,
  output aalr_pkg::status_t      status,
  input  logic [COORD_BITS-1:0]  x_start,
  input  logic [COORD_BITS-1:0]  y_start,
  input  logic [COORD_BITS-1:0]  x_end,
  input  logic [COORD_BITS-1:0]  y_end,
  output logic [COORD_BITS-1:0]  pix_x,
  output logic [COORD_BITS-1:0]  pix_y,
  output logic                   steep_line,
  output logic [WEIGHT_BITS-1:0] weight_lower,
  output logic [WEIGHT_BITS-1:0] weight_upper,
  output logic                   last
);

  localparam int ACC_W   = COORD_BITS + FRAC_BITS;
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int SLOPE_W = FRAC_BITS + 2;
  localparam int PROD_W  = FRAC_BITS + WEIGHT_BITS;
  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

  // line state
  logic                  transposed;
  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] major_stop;
  logic [COORD_BITS-1:0] start_minor;
  logic [COORD_BITS-1:0] stop_minor;
  logic [ACC_W-1:0]      minor_acc;
  logic [SLOPE_W-1:0]    slope;

  // divider
  logic [COORD_BITS-1:0] dmaj;
  logic [COORD_BITS-1:0] rem;
  logic                  rem_bit;
  logic [Q_W-1:0]        quot;
  logic                  dmin_neg;
  logic                  zero_len;

  // load-side terms
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  tr;
  logic [COORD_BITS-1:0] ma, mi, mb, mj;
  logic                  swap;
  logic [COORD_BITS-1:0] lo_maj, lo_min, hi_maj, hi_min;
  logic [COORD_BITS-1:0] abs_dmin;

  logic [COORD_BITS:0]   trial;
  logic                  q_bit;
  logic [COORD_BITS:0]   trial_sub;
  logic [Q_W-1:0]        quot_next;
  logic [SLOPE_W-1:0]    slope_div;

  logic [COORD_BITS-1:0] pos_inc;
  logic [ACC_W-1:0]      slope_ext;
  logic [FRAC_BITS-1:0]  frac;
  logic [PROD_W-1:0]     wprod;
  logic [WEIGHT_BITS-1:0] wu;
  logic [COORD_BITS-1:0] col_maj;
  logic [COORD_BITS-1:0] col_min;

  assign adx  = (x_end > x_start) ? x_end - x_start : x_start - x_end;
  assign ady  = (y_end > y_start) ? y_end - y_start : y_start - y_end;
  assign tr   = ady > adx;
  assign ma   = tr ? y_start : x_start;
  assign mi   = tr ? x_start : y_start;
  assign mb   = tr ? y_end   : x_end;
  assign mj   = tr ? x_end   : y_end;
  assign swap = ma > mb;
  assign lo_maj = swap ? mb : ma;
  assign lo_min = swap ? mj : mi;
  assign hi_maj = swap ? ma : mb;
  assign hi_min = swap ? mi : mj;
  // |d_minor| never exceeds |d_major|, so the quotient fits FRAC_BITS+1 bits
  assign abs_dmin = tr ? adx : ady;

  // one restoring step per cycle over the quotient bits
  assign trial     = {rem, rem_bit};
  assign q_bit     = trial >= {1'b0, dmaj};
  assign trial_sub = trial - {1'b0, dmaj};
  assign quot_next = {quot[Q_W-2:0], q_bit};
  assign slope_div = zero_len ? '0 :
                     dmin_neg ? SLOPE_W'(-{1'b0, quot_next}) : {1'b0, quot_next};

  assign pos_inc   = major_pos + 1'b1;
  assign slope_ext = {{(ACC_W-SLOPE_W){slope[SLOPE_W-1]}}, slope};
  assign frac      = minor_acc[FRAC_BITS-1:0];
  // frac * WMAX as a shift and subtract
  assign wprod     = {frac, {WEIGHT_BITS{1'b0}}} - {{WEIGHT_BITS{1'b0}}, frac};
  assign wu        = wprod[PROD_W-1:FRAC_BITS];

  assign status.at_stop      = major_pos == major_stop;
  assign status.next_at_stop = pos_inc == major_stop;

  always_comb begin
    col_maj = major_pos;
    col_min = start_minor;
    if (cmd.emit_mid) begin
      col_min = minor_acc[ACC_W-1:FRAC_BITS];
    end else if (cmd.emit_end) begin
      col_maj = major_stop;
      col_min = stop_minor;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      transposed  <= tr;
      major_pos   <= lo_maj;
      major_stop  <= hi_maj;
      start_minor <= lo_min;
      stop_minor  <= hi_min;
      minor_acc   <= '0;
      dmaj        <= hi_maj - lo_maj;
      dmin_neg    <= hi_min < lo_min;
      zero_len    <= hi_maj == lo_maj;
      rem         <= abs_dmin >> 1;
      rem_bit     <= abs_dmin[0];
      quot        <= '0;
    end
    if (cmd.div_step) begin
      rem     <= q_bit ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      rem_bit <= 1'b0;
      quot    <= quot_next;
    end
    if (cmd.div_last) begin
      slope <= slope_div;
    end
    if (cmd.emit_start && !status.at_stop) begin
      major_pos <= pos_inc;
      minor_acc <= {start_minor, {FRAC_BITS{1'b0}}} + slope_ext;
    end
    if (cmd.emit_mid) begin
      major_pos <= pos_inc;
      minor_acc <= minor_acc + slope_ext;
    end
    if (cmd.emit_start || cmd.emit_mid || cmd.emit_end) begin
      pix_x        <= transposed ? col_min : col_maj;
      pix_y        <= transposed ? col_maj : col_min;
      steep_line   <= transposed;
      weight_lower <= cmd.emit_mid ? WMAX - wu : WMAX;
      weight_upper <= cmd.emit_mid ? wu : '0;
      last         <= cmd.emit_end || (cmd.emit_start && status.at_stop);
    end
  end

endmodule

FILE: design/antialiased_line_rasterizer.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Antialiased line rasterizer: one column pair with complementary weights
// per step request.
// ----------------------------------------------------------------------------
// A load item (func 0) takes two endpoints, and a restoring divider then forms
// the gradient, one quotient bit a cycle; the input stalls while it runs. Each
// step item (func 1) then yields one column: the start endpoint at full weight,
// the interior columns, and the end endpoint with last set. Steps while no line
// is active produce nothing. A column result sits in an output register, and
// the next step is taken in the same cycle in which the previous result
// transfers. steep_line marks columns whose neighbor pixel lies at x plus one.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS  = aalr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = aalr_pkg::FRAC_BITS_DEF,
  parameter int WEIGHT_BITS = aalr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   func,
  input  logic [COORD_BITS-1:0]  x_start,
  input  logic [COORD_BITS-1:0]  y_start,
  input  logic [COORD_BITS-1:0]  x_end,
  input  logic [COORD_BITS-1:0]  y_end,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [COORD_BITS-1:0]  pix_x,
  output logic [COORD_BITS-1:0]  pix_y,
  output logic                   steep_line,
  output logic [WEIGHT_BITS-1:0] weight_lower,
  output logic [WEIGHT_BITS-1:0] weight_upper,
  output logic                   last
);

  aalr_pkg::cmd_t    cmd;
  aalr_pkg::status_t status;

  aalr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  aalr_datapath #(
    .COORD_BITS  (COORD_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .steep_line   (steep_line),
    .weight_lower (weight_lower),
    .weight_upper (weight_upper),
    .last         (last)
  );

endmodule

FILE: tb/antialiased_line_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_tb
// Drives load and step commands into the line rasterizer with random idle
// cycles on both sides. A line tracer predicts every column, and the monitor
// checks each column that transfers against the oldest prediction.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_tb;

  localparam int CB = aalr_pkg::COORD_BITS_DEF;
  localparam int FB = aalr_pkg::FRAC_BITS_DEF;
  localparam int WB = aalr_pkg::WEIGHT_BITS_DEF;
  localparam longint unsigned COORD_MASK = (64'd1 << CB) - 1;
  localparam longint unsigned FRAC_MASK  = (64'd1 << FB) - 1;
  localparam int WEIGHT_FULL = (1 << WB) - 1;
  localparam int COORD_TOP = (1 << CB) - 1;
  localparam int RANDOM_CMDS = 1400;
  localparam int RANDOM_CHUNKS = 4;
  localparam int MAX_WAIT = 18;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  typedef struct packed {
    logic          func;
    logic [CB-1:0] xs;
    logic [CB-1:0] ys;
    logic [CB-1:0] xe;
    logic [CB-1:0] ye;
  } line_cmd_t;

  typedef struct packed {
    logic [CB-1:0] pix_x;
    logic [CB-1:0] pix_y;
    logic          steep;
    logic [WB-1:0] w_lo;
    logic [WB-1:0] w_hi;
    logic          is_last;
  } column_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_stall;
  logic          func = aalr_pkg::FUNC_LOAD;
  logic [CB-1:0] x_start = '0;
  logic [CB-1:0] y_start = '0;
  logic [CB-1:0] x_end = '0;
  logic [CB-1:0] y_end = '0;
  logic          result_valid;
  logic          result_stall = 1'b0;
  logic [CB-1:0] pix_x;
  logic [CB-1:0] pix_y;
  logic          steep_line;
  logic [WB-1:0] weight_lower;
  logic [WB-1:0] weight_upper;
  logic          last;

  antialiased_line_rasterizer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .steep_line   (steep_line),
    .weight_lower (weight_lower),
    .weight_upper (weight_upper),
    .last         (last)
  );

  always #6 clk = ~clk;

  line_cmd_t pending_cmds[$];
  column_t   expected_columns[$];
  int        errors = 0;
  int        n_cmds_taken = 0;
  int        n_columns = 0;
  logic      hold_sink = 1'b0;

  // Line tracer state
  bit               ln_busy = 1'b0;
  bit               ln_steep = 1'b0;
  logic [1:0]       ln_phase = PH_START;
  int               ln_major = 0;
  int               ln_major_end = 0;
  longint unsigned  ln_minor_acc = 0;
  longint           ln_slope = 0;
  int               ln_minor_first = 0;
  int               ln_minor_last = 0;

  function automatic column_t make_column(int maj, int mino, int wl, int wu, bit lst);
    column_t c;
    logic [CB-1:0] a;
    logic [CB-1:0] b;
    a = maj[CB-1:0];
    b = mino[CB-1:0];
    c.pix_x   = ln_steep ? b : a;
    c.pix_y   = ln_steep ? a : b;
    c.steep   = ln_steep;
    c.w_lo    = wl[WB-1:0];
    c.w_hi    = wu[WB-1:0];
    c.is_last = lst;
    return c;
  endfunction

  function automatic int draw_wait(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, MAX_WAIT);
    return ($urandom_range(0, 5) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // Advance the predicted line by one accepted command.
  task automatic trace_line(input line_cmd_t cmd);
    int ma, mi, mb, mj, t, adx, ady, dmaj, dmin;
    longint unsigned mag;
    longint unsigned frac;
    int wu;
    if (cmd.func == aalr_pkg::FUNC_LOAD) begin
      adx = (cmd.xe > cmd.xs) ? int'(cmd.xe) - int'(cmd.xs) : int'(cmd.xs) - int'(cmd.xe);
      ady = (cmd.ye > cmd.ys) ? int'(cmd.ye) - int'(cmd.ys) : int'(cmd.ys) - int'(cmd.ye);
      ln_steep = (ady > adx);
      if (ln_steep) begin
        ma = int'(cmd.ys); mi = int'(cmd.xs); mb = int'(cmd.ye); mj = int'(cmd.xe);
      end else begin
        ma = int'(cmd.xs); mi = int'(cmd.ys); mb = int'(cmd.xe); mj = int'(cmd.ye);
      end
      if (ma > mb) begin
        t = ma; ma = mb; mb = t;
        t = mi; mi = mj; mj = t;
      end
      dmaj = mb - ma;
      dmin = mj - mi;
      if (dmaj == 0) begin
        ln_slope = 0;
      end else begin
        mag = longint'(dmin < 0 ? -dmin : dmin) << FB;
        mag = mag / longint'(dmaj);
        ln_slope = (dmin < 0) ? -longint'(mag) : longint'(mag);
      end
      ln_major       = ma;
      ln_major_end   = mb;
      ln_minor_first = mi;
      ln_minor_last  = mj;
      ln_minor_acc   = 0;
      ln_phase       = PH_START;
      ln_busy        = 1'b1;
    end else if (ln_busy) begin
      if (ln_phase == PH_START) begin
        if (ln_major == ln_major_end) begin
          expected_columns.push_back(make_column(ln_major, ln_minor_first, WEIGHT_FULL, 0, 1'b1));
          ln_busy = 1'b0;
        end else begin
          expected_columns.push_back(make_column(ln_major, ln_minor_first, WEIGHT_FULL, 0, 1'b0));
          ln_major = (ln_major + 1) & COORD_TOP;
          ln_minor_acc = (longint'(ln_minor_first) << FB) + $unsigned(ln_slope);
          ln_phase = (ln_major == ln_major_end) ? PH_END : PH_MID;
        end
      end else if (ln_phase == PH_MID) begin
        frac = ln_minor_acc & FRAC_MASK;
        wu = int'((frac * WEIGHT_FULL) >> FB);
        expected_columns.push_back(make_column(ln_major, int'((ln_minor_acc >> FB) & COORD_MASK),
                                               WEIGHT_FULL - wu, wu, 1'b0));
        ln_major = (ln_major + 1) & COORD_TOP;
        ln_minor_acc = ln_minor_acc + $unsigned(ln_slope);
        if (ln_major == ln_major_end) ln_phase = PH_END;
      end else begin
        expected_columns.push_back(make_column(ln_major_end, ln_minor_last, WEIGHT_FULL, 0, 1'b1));
        ln_busy = 1'b0;
        ln_phase = PH_START;
      end
    end
  endtask

  // Command driver
  line_cmd_t cur_cmd;
  bit        cmd_loaded = 1'b0;
  int        cmd_gap = 0;
  int        src_mode = 1;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      cmd_loaded = 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        trace_line(cur_cmd);
        cmd_loaded = 1'b0;
        n_cmds_taken++;
        if (n_cmds_taken % 64 == 0) src_mode = $urandom_range(0, 2);
      end
      if (!cmd_loaded && pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        cmd_loaded = 1'b1;
        cmd_gap = draw_wait(src_mode);
      end
      if (!cmd_loaded) begin
        item_valid <= 1'b0;
      end else if (!item_valid || !item_stall) begin
        // not holding a stalled transfer: count down the gap, then offer
        if (cmd_gap > 0) begin
          cmd_gap--;
          item_valid <= 1'b0;
        end else begin
          item_valid <= 1'b1;
          func    <= cur_cmd.func;
          x_start <= cur_cmd.xs;
          y_start <= cur_cmd.ys;
          x_end   <= cur_cmd.xe;
          y_end   <= cur_cmd.ye;
        end
      end
    end
  end

  // Column monitor
  int sink_wait = 0;
  int sink_mode = 1;

  always @(posedge clk) begin
    column_t got;
    column_t want;
    if (rst) begin
      result_stall <= 1'b0;
      sink_wait = 0;
    end else begin
      if (result_valid && !result_stall) begin
        got = {pix_x, pix_y, steep_line, weight_lower, weight_upper, last};
        if (expected_columns.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected column: x=%0d y=%0d steep=%0b wl=%0d wu=%0d last=%0b",
                     got.pix_x, got.pix_y, got.steep, got.w_lo, got.w_hi, got.is_last);
        end else begin
          want = expected_columns.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"column mismatch: expected x=%0d y=%0d steep=%0b wl=%0d wu=%0d ",
                        "last=%0b, got x=%0d y=%0d steep=%0b wl=%0d wu=%0d last=%0b"},
                       want.pix_x, want.pix_y, want.steep, want.w_lo, want.w_hi,
                       want.is_last, got.pix_x, got.pix_y, got.steep, got.w_lo,
                       got.w_hi, got.is_last);
          end
        end
        n_columns++;
        if (n_columns % 64 == 0) sink_mode = $urandom_range(0, 2);
        sink_wait = draw_wait(sink_mode);
      end
      if (hold_sink) begin
        result_stall <= 1'b1;
      end else if (sink_wait > 0) begin
        sink_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs while commands keep coming
  initial begin
    while (n_cmds_taken < 200) @(posedge clk);
    hold_sink <= 1'b1;
    repeat (300) @(posedge clk);
    hold_sink <= 1'b0;
    while (n_cmds_taken < 800) @(posedge clk);
    hold_sink <= 1'b1;
    repeat (400) @(posedge clk);
    hold_sink <= 1'b0;
  end

  initial begin
    #(12 * 1000000);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_cmd(logic f, int xs, int ys, int xe, int ye);
    line_cmd_t c;
    c.func = f;
    c.xs = xs[CB-1:0];
    c.ys = ys[CB-1:0];
    c.xe = xe[CB-1:0];
    c.ye = ye[CB-1:0];
    pending_cmds.push_back(c);
  endtask

  task automatic push_steps(int n);
    repeat (n) push_cmd(aalr_pkg::FUNC_STEP, 0, 0, 0, 0);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return COORD_TOP;
      default: return $urandom_range(0, COORD_TOP);
    endcase
  endfunction

  function automatic int offset_coord(int base, int d);
    int v;
    v = $urandom_range(0, 1) ? base + d : base - d;
    if (v > COORD_TOP) v = base - d;
    if (v < 0) v = base + d;
    return v;
  endfunction

  // Queue one random line, mostly run to completion; return commands counted, apart from steps past the end.
  task automatic queue_random_line(output int n);
    int len, dmin, maj0, min0, maj1, min1, cols, steps, kind;
    len = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
    case ($urandom_range(0, 7))
      0:       dmin = 0;
      1:       dmin = len;
      default: dmin = $urandom_range(0, len);
    endcase
    maj0 = pick_coord();
    min0 = pick_coord();
    maj1 = offset_coord(maj0, len);
    min1 = offset_coord(min0, dmin);
    if ($urandom_range(0, 1)) push_cmd(aalr_pkg::FUNC_LOAD, min0, maj0, min1, maj1);
    else push_cmd(aalr_pkg::FUNC_LOAD, maj0, min0, maj1, min1);
    cols = len + 1;
    kind = $urandom_range(0, 19);
    if (kind < 16) begin
      steps = cols;
    end else if (kind < 19) begin
      // abandon the line early, the next load replaces it
      steps = $urandom_range(0, len);
    end else begin
      // step past the end; the extra steps are ignored
      steps = cols;
      push_steps(steps);
      push_steps($urandom_range(1, 3));
      n = 1 + steps;
      return;
    end
    push_steps(steps);
    n = 1 + steps;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_loaded || item_valid ||
           expected_columns.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int n_items;
    int chunk_items;
    int n;
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed lines
    // step with no line
    push_cmd(aalr_pkg::FUNC_STEP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
    // zero-length line
    push_cmd(aalr_pkg::FUNC_LOAD, 0, 0, 0, 0);
    push_steps(2);
    push_cmd(aalr_pkg::FUNC_LOAD, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
    push_steps(1);
    push_cmd(aalr_pkg::FUNC_LOAD, 10, 5, 6, 7);              // reversed, falling
    push_steps(5);
    push_cmd(aalr_pkg::FUNC_LOAD, 3, 0, 5, 4);               // steep
    push_steps(5);
    push_cmd(aalr_pkg::FUNC_LOAD, 0, COORD_TOP, COORD_TOP, 0);  // full-range diagonal
    push_steps(2);
    push_cmd(aalr_pkg::FUNC_LOAD, 7, 9, 7, 11);              // replaces it, vertical
    push_steps(3);
    wait_drained();

    n_items = 0;
    for (k = 0; k < RANDOM_CHUNKS; k++) begin
      chunk_items = 0;
      while (chunk_items < RANDOM_CMDS / RANDOM_CHUNKS) begin
        if ($urandom_range(0, 19) == 0) begin
          // noise: arbitrary commands
          repeat ($urandom_range(1, 3)) begin
            push_cmd(1'($urandom_range(0, 1)), $urandom_range(0, COORD_TOP),
                     $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
                     $urandom_range(0, COORD_TOP));
            chunk_items++;
          end
        end else begin
          queue_random_line(n);
          chunk_items += n;
        end
      end
      n_items += chunk_items;
      // hold the source until every column of this chunk has arrived
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (expected_columns.size() != 0) errors += expected_columns.size();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
